// ----- src/av_tsi_pkg.sv -----
// ----------------------------------------------------------------------------
// av_tsi_pkg
// Types and constants shared by the audio/video timestamp interleaver.
// ----------------------------------------------------------------------------
package av_tsi_pkg;

    // Request codes of an input transfer.
    localparam logic [1:0] REQ_PUSH   = 2'd0;
    localparam logic [1:0] REQ_MARKER = 2'd1;
    localparam logic [1:0] REQ_FLUSH  = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SCALE  = 2'd0;
    localparam logic [1:0] CFG_UNIT   = 2'd1;
    localparam logic [1:0] CFG_ALIMIT = 2'd2;
    localparam logic [1:0] CFG_VLIMIT = 2'd3;

    // Configuration reset values.
    localparam logic [31:0] SCALE_RST  = 32'd1000000;
    localparam logic [19:0] UNIT_RST   = 20'd100;
    localparam logic [5:0]  ALIMIT_RST = 6'd32;
    localparam logic [4:0]  VLIMIT_RST = 5'd16;

    // Stored frame descriptor: key, tag, pts.
    localparam int unsigned ENTRY_W = 97;

    typedef struct packed {
        logic        is_video;
        logic [63:0] pts;
        logic [31:0] tag;
        logic        key;
        logic        marker;
        logic        misuse;
        logic        status_ok;
    } t_result;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_DROP,
        S_WRITE,
        S_REL,
        S_VRD,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_DIV,
        S_SDONE,
        S_ACHK,
        S_AFTER,
        S_POPA,
        S_POPV,
        S_FLA,
        S_FLPOP,
        S_MARK,
        S_MISUSE,
        S_FIN
    } t_state;

endpackage

// ----- src/av_timestamp_interleaver_core.sv -----
// ----------------------------------------------------------------------------
// av_timestamp_interleaver_core
// Merges audio and video frame descriptors into one stream in timestamp order.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+-------------------------
//  request  | in        | i_in_valid / o_in_stall   | req, frame fields
//  result   | out       | o_out_valid / i_out_stall | released frame, flags
//  config   | in        | i_cfg_valid / o_cfg_ready | index, data
//
//  Every timestamp comparison runs the shared scaling unit: two 32x20
//  multiply steps, one add and a 64-step restoring divider, one quotient
//  bit per cycle.
//  Reset is synchronous and active low; it empties both queues and restores
//  the configuration defaults. The stores themselves are not cleared.
//  A stalled result holds the sequencer, which waits before producing the
//  next one; the request channel is stalled until the request is complete.
//
module av_timestamp_interleaver_core
    import av_tsi_pkg::*;
#(
    parameter int unsigned VIDEO_DEPTH = 16,
    parameter int unsigned AUDIO_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic        i_is_video,
    input  logic [63:0] i_frame_pts,
    input  logic [31:0] i_frame_tag,
    input  logic        i_key_in,
    input  logic        i_fragment_end_in,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_out_is_video,
    output logic [63:0] o_out_pts,
    output logic [31:0] o_out_tag,
    output logic        o_out_key,
    output logic        o_out_marker,
    output logic        o_out_misuse,
    output logic        o_status_ok,
    output logic        o_last,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int unsigned VAW = (VIDEO_DEPTH > 1) ? $clog2(VIDEO_DEPTH) : 1;
    localparam int unsigned AAW = (AUDIO_DEPTH > 1) ? $clog2(AUDIO_DEPTH) : 1;
    localparam int unsigned VCW = $clog2(VIDEO_DEPTH + 1);
    localparam int unsigned ACW = $clog2(AUDIO_DEPTH + 1);

    // Configuration registers.
    logic [31:0] r_scale;
    logic [19:0] r_unit;
    logic [5:0]  r_alim;
    logic [4:0]  r_vlim;

    // Sequencer and queue state.
    t_state r_state, n_state;
    logic [VAW-1:0] r_vhead;
    logic [VCW-1:0] r_vcount;
    logic [AAW-1:0] r_ahead;
    logic [ACW-1:0] r_acount;
    logic r_marker_pend;
    logic r_status;

    // Latched request.
    logic [1:0]  r_req;
    logic        r_is_video;
    logic [63:0] r_pts;
    logic [31:0] r_tag;
    logic        r_key;
    logic        r_eofr;

    // Queue stores and their registered read data.
    logic [ENTRY_W-1:0] r_vmem [VIDEO_DEPTH];
    logic [ENTRY_W-1:0] r_amem [AUDIO_DEPTH];
    logic [ENTRY_W-1:0] r_vrd;
    logic [ENTRY_W-1:0] r_ard;

    // Shared scaling unit.
    logic        r_sel_v;
    logic [51:0] r_mp;
    logic [63:0] r_q;
    logic [31:0] r_rem;
    logic [5:0]  r_cnt;
    logic [63:0] r_vs;

    // Result holding: one pending result (last not yet known) and the output.
    logic    r_pend_v;
    t_result r_pend;
    logic    r_out_v;
    t_result r_out;
    logic    r_out_last;

    // ------------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------------
    logic [6:0] alim_eff, vlim_eff;
    logic       a_full, v_full;
    logic [7:0] a_wsum, v_wsum;
    logic [AAW-1:0] a_widx;
    logic [VAW-1:0] v_widx;
    logic [AAW-1:0] a_head_nx;
    logic [VAW-1:0] v_head_nx;
    logic [63:0] scale_x;
    logic [31:0] mul_a;
    logic [31:0] divisor;
    logic [32:0] rem2;
    logic        div_ge;
    logic [32:0] div_diff;
    logic        can_emit;
    logic        flush;
    logic        in_acc;

    always_comb begin
        if (r_alim == 6'd0) begin
            alim_eff = 7'd1;
        end else if (7'(r_alim) > 7'(AUDIO_DEPTH)) begin
            alim_eff = 7'(AUDIO_DEPTH);
        end else begin
            alim_eff = 7'(r_alim);
        end
        if (r_vlim == 5'd0) begin
            vlim_eff = 7'd1;
        end else if (7'(r_vlim) > 7'(VIDEO_DEPTH)) begin
            vlim_eff = 7'(VIDEO_DEPTH);
        end else begin
            vlim_eff = 7'(r_vlim);
        end
    end

    assign a_full = 7'(r_acount) >= alim_eff;
    assign v_full = 7'(r_vcount) >= vlim_eff;

    assign a_wsum = 8'(r_ahead) + 8'(r_acount);
    assign v_wsum = 8'(r_vhead) + 8'(r_vcount);
    assign a_widx = AAW'((a_wsum >= 8'(AUDIO_DEPTH)) ? a_wsum - 8'(AUDIO_DEPTH) : a_wsum);
    assign v_widx = VAW'((v_wsum >= 8'(VIDEO_DEPTH)) ? v_wsum - 8'(VIDEO_DEPTH) : v_wsum);

    assign a_head_nx = (r_ahead == AAW'(AUDIO_DEPTH - 1)) ? '0 : r_ahead + 1'b1;
    assign v_head_nx = (r_vhead == VAW'(VIDEO_DEPTH - 1)) ? '0 : r_vhead + 1'b1;

    // The entry layout is {key, tag, pts}; the unit scales the pts field.
    assign scale_x  = r_sel_v ? r_vrd[63:0] : r_ard[63:0];
    assign mul_a    = (r_state == S_MUL0) ? scale_x[31:0] : scale_x[63:32];
    assign divisor  = (r_scale == 32'd0) ? 32'd1 : r_scale;
    assign rem2     = {r_rem, r_q[63]};
    assign div_ge   = rem2 >= {1'b0, divisor};
    assign div_diff = rem2 - {1'b0, divisor};

    // A new result may be produced once the pending one can move on.
    assign can_emit = !r_pend_v || !r_out_v;
    assign flush    = (r_req == REQ_FLUSH);
    assign in_acc   = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_DECODE;
            end
            S_DECODE: begin
                unique case (r_req)
                    REQ_PUSH:   n_state = r_eofr ? S_MISUSE : S_DROP;
                    REQ_MARKER: n_state = S_MARK;
                    REQ_FLUSH:  n_state = S_REL;
                    REQ_NONE:   n_state = S_FIN;
                endcase
            end
            S_DROP: begin
                if (!(r_is_video ? v_full : a_full)) n_state = S_WRITE;
            end
            S_WRITE: n_state = S_REL;
            S_REL: begin
                if (r_vcount != '0) begin
                    n_state = S_VRD;
                end else if (flush && r_acount != '0) begin
                    n_state = S_FLA;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_VRD:  n_state = S_MUL0;
            S_MUL0: n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == 6'd63) n_state = S_SDONE;
            end
            S_SDONE: begin
                if (r_sel_v) begin
                    n_state = S_ACHK;
                end else begin
                    n_state = (r_q < r_vs) ? S_POPA : S_AFTER;
                end
            end
            S_ACHK: n_state = (r_acount == '0) ? S_AFTER : S_MUL0;
            S_AFTER: begin
                n_state = (flush || r_acount != '0) ? S_POPV : S_FIN;
            end
            S_POPA: begin
                if (can_emit) n_state = S_ACHK;
            end
            S_POPV: begin
                if (can_emit) n_state = flush ? S_REL : S_FIN;
            end
            S_FLA: n_state = S_FLPOP;
            S_FLPOP: begin
                if (can_emit) n_state = S_REL;
            end
            S_MARK: begin
                if (can_emit) n_state = S_FIN;
            end
            S_MISUSE: begin
                if (can_emit) n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_pend_v || !r_out_v) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // Control outputs of the sequencer
    // ------------------------------------------------------------------------
    logic    emit;
    t_result emit_res;
    logic    force_key;

    always_comb begin
        emit      = 1'b0;
        force_key = !flush && r_marker_pend;
        emit_res  = '0;
        emit_res.status_ok = r_status;
        unique case (r_state)
            S_POPA, S_FLPOP: begin
                emit              = can_emit;
                emit_res.is_video = 1'b0;
                emit_res.pts      = r_ard[63:0];
                emit_res.tag      = r_ard[95:64];
                emit_res.key      = r_ard[96] | force_key;
            end
            S_POPV: begin
                emit              = can_emit;
                emit_res.is_video = 1'b1;
                emit_res.pts      = r_vrd[63:0];
                emit_res.tag      = r_vrd[95:64];
                emit_res.key      = r_vrd[96] | force_key;
            end
            S_MARK: begin
                emit            = can_emit;
                emit_res.marker = 1'b1;
            end
            S_MISUSE: begin
                emit               = can_emit;
                emit_res.misuse    = 1'b1;
                emit_res.status_ok = 1'b0;
            end
            default: emit = 1'b0;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_vhead       <= '0;
            r_vcount      <= '0;
            r_ahead       <= '0;
            r_acount      <= '0;
            r_marker_pend <= 1'b0;
            r_status      <= 1'b1;
            r_pend_v      <= 1'b0;
            r_out_v       <= 1'b0;
            r_scale       <= SCALE_RST;
            r_unit        <= UNIT_RST;
            r_alim        <= ALIMIT_RST;
            r_vlim        <= VLIMIT_RST;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SCALE:  r_scale <= i_cfg_data;
                    CFG_UNIT:   r_unit  <= i_cfg_data[19:0];
                    CFG_ALIMIT: r_alim  <= i_cfg_data[5:0];
                    CFG_VLIMIT: r_vlim  <= i_cfg_data[4:0];
                endcase
            end

            // Drop the oldest entry while the queue sits at its limit.
            if (r_state == S_DROP) begin
                if (r_is_video && v_full) begin
                    r_vhead  <= v_head_nx;
                    r_vcount <= r_vcount - 1'b1;
                end else if (!r_is_video && a_full) begin
                    r_ahead  <= a_head_nx;
                    r_acount <= r_acount - 1'b1;
                end
            end
            if (r_state == S_WRITE) begin
                if (r_is_video) begin
                    r_vcount <= r_vcount + 1'b1;
                end else begin
                    r_acount <= r_acount + 1'b1;
                end
            end
            if (emit && (r_state == S_POPA || r_state == S_FLPOP)) begin
                r_ahead  <= a_head_nx;
                r_acount <= r_acount - 1'b1;
            end
            if (emit && r_state == S_POPV) begin
                r_vhead  <= v_head_nx;
                r_vcount <= r_vcount - 1'b1;
            end
            if (emit && force_key
                && (r_state == S_POPA || r_state == S_FLPOP || r_state == S_POPV)) begin
                r_marker_pend <= 1'b0;
            end
            if (emit && r_state == S_MARK) begin
                r_marker_pend <= 1'b1;
            end
            if (r_state == S_MISUSE) begin
                r_status <= 1'b0;
            end

            // Result path: pending -> output on every new result, and at the end.
            if (r_out_v && !i_out_stall) begin
                r_out_v <= 1'b0;
            end
            if (emit) begin
                r_pend_v <= 1'b1;
                if (r_pend_v) r_out_v <= 1'b1;
            end else if (r_state == S_FIN && r_pend_v && !r_out_v) begin
                r_pend_v <= 1'b0;
                r_out_v  <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req      <= i_req_type;
            r_is_video <= i_is_video;
            r_pts      <= i_frame_pts;
            r_tag      <= i_frame_tag;
            r_key      <= i_key_in;
            r_eofr     <= i_fragment_end_in;
        end

        if (emit) begin
            r_pend <= emit_res;
            if (r_pend_v) begin
                r_out      <= r_pend;
                r_out_last <= 1'b0;
            end
        end else if (r_state == S_FIN && r_pend_v && !r_out_v) begin
            r_out      <= r_pend;
            r_out_last <= 1'b1;
        end

        if (r_state == S_VRD)  r_sel_v <= 1'b1;
        if (r_state == S_ACHK) r_sel_v <= 1'b0;

        // Product modulo 2^64 in two 32x20 halves, then restoring division.
        unique case (r_state)
            S_MUL0: r_mp <= mul_a * r_unit;
            S_MUL1: begin
                r_mp <= mul_a * r_unit;
                r_q  <= 64'(r_mp);
            end
            S_MUL2: begin
                r_q   <= r_q + {r_mp[31:0], 32'd0};
                r_rem <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem <= div_ge ? div_diff[31:0] : rem2[31:0];
                r_q   <= {r_q[62:0], div_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            default: r_cnt <= r_cnt;
        endcase

        if (r_state == S_SDONE && r_sel_v) r_vs <= r_q;
    end

    // Queue stores: one write port, one registered read at the head.
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE && r_is_video) begin
            r_vmem[v_widx] <= {r_key, r_tag, r_pts};
        end
        r_vrd <= r_vmem[r_vhead];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE && !r_is_video) begin
            r_amem[a_widx] <= {r_key, r_tag, r_pts};
        end
        r_ard <= r_amem[r_ahead];
    end

    // ------------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------------
    assign o_out_valid    = r_out_v;
    assign o_out_is_video = r_out.is_video;
    assign o_out_pts      = r_out.pts;
    assign o_out_tag      = r_out.tag;
    assign o_out_key      = r_out.key;
    assign o_out_marker   = r_out.marker;
    assign o_out_misuse   = r_out.misuse;
    assign o_status_ok    = r_out.status_ok;
    assign o_last         = r_out_last;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
    a_acount_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        7'(r_acount) <= 7'(AUDIO_DEPTH))
        else $error("audio fill exceeds store depth");

    a_vcount_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        7'(r_vcount) <= 7'(VIDEO_DEPTH))
        else $error("video fill exceeds store depth");

    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_marker) |-> o_last)
        else $error("marker result not marked last");

    a_misuse_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_misuse) |-> (!o_status_ok && o_last))
        else $error("misuse result with good status or not last");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("result left pending after request completed");
`endif

endmodule
